// File: design/fi2_pkg.sv
// fi2_pkg: shared widths, constants and the odd-phase coefficient rom for the
// x2 polyphase interpolator. No dependencies; used by every design file.
package fi2_pkg;

    // sample and result width (signed q15)
    localparam int SAMPLE_W  = 16;
    // fractional bits of the coefficient rom
    localparam int COEF_FRAC = 15;
    localparam int COEF_W    = 16;
    // accumulator: 30 products of 16x16 plus headroom
    localparam int ACC_W     = 34;
    // odd-phase taps, one per cell
    localparam int NUM_CELLS = 30;
    // input samples between a sample and its output pair
    localparam int LAG       = 15;
    localparam int CNT_W     = 4;

    // odd-phase subfilter, cell 0 multiplies the newest sample
    localparam logic signed [COEF_W-1:0] ODD_COEF [NUM_CELLS] = '{
        16'sd59,    -16'sd79,   16'sd118,   -16'sd180,  16'sd268,
        -16'sd387,  16'sd545,   -16'sd751,  16'sd1020,  -16'sd1379,
        16'sd1878,  -16'sd2628, 16'sd3915,  -16'sd6797, 16'sd20808,
        16'sd20808, -16'sd6797, 16'sd3915,  -16'sd2628, 16'sd1878,
        -16'sd1379, 16'sd1020,  -16'sd751,  16'sd545,   -16'sd387,
        16'sd268,   -16'sd180,  16'sd118,   -16'sd79,   16'sd59
    };

    // control broadcast along the cell chain
    typedef struct packed {
        logic advance;  // a sample beat is taken this cycle
        logic clear;    // drop all earlier history first
    } chain_ctrl_t;

endpackage

// File: design/fi2_tap_cell.sv
// fi2_tap_cell: one cell of the transposed odd-phase filter chain.
// Holds one partial sum; depends on fi2_pkg.
module fi2_tap_cell
    import fi2_pkg::*;
#(
    parameter logic signed [COEF_W-1:0] COEF = '0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  chain_ctrl_t                ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [ACC_W-1:0]    acc_in,
    output logic signed [ACC_W-1:0]    acc_out
);

    logic signed [SAMPLE_W+COEF_W-1:0] prod;
    logic signed [ACC_W-1:0]           carry;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;

    // product of the broadcast sample and this cell's tap
    assign prod  = sample * COEF;
    // restart drops the partial sum coming from the neighbour
    assign carry = ctrl.clear ? '0 : acc_in;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.advance)
        begin
            acc_next = carry + ACC_W'(prod);
        end
    end

    // partial sum register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

// File: design/fi2_pair_out.sv
// fi2_pair_out: output pair buffer with round-and-saturate of the odd phase.
// Sends the even beat then the odd beat; depends on fi2_pkg.
module fi2_pair_out
    import fi2_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pend,
    input  logic signed [ACC_W-1:0]    acc,
    input  logic signed [SAMPLE_W-1:0] even,
    output logic                       take,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] value,
    output logic                       last
);

    localparam int SH_W = ACC_W - COEF_FRAC;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_M1 = HALF - ACC_W'(1);
    localparam logic signed [SH_W-1:0]  SAT_HI  = SH_W'(32767);
    localparam logic signed [SH_W-1:0]  SAT_LO  = -SH_W'(32768);

    logic                       pair_valid_reg;
    logic                       pair_valid_next;
    logic                       phase_reg;
    logic                       phase_next;
    logic signed [SAMPLE_W-1:0] even_reg;
    logic signed [SAMPLE_W-1:0] odd_reg;
    logic signed [ACC_W-1:0]    biased;
    logic signed [SH_W-1:0]     shifted;
    logic signed [SAMPLE_W-1:0] odd_sat;
    logic                       beat_done;

    // round half away from zero: bias one less below zero, then floor
    assign biased  = acc + (acc[ACC_W-1] ? HALF_M1 : HALF);
    assign shifted = biased[ACC_W-1:COEF_FRAC];

    // clamp to int16
    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            odd_sat = SAMPLE_W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            odd_sat = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            odd_sat = shifted[SAMPLE_W-1:0];
        end
    end

    // pair slot frees on the odd beat, so a new pair can load at once
    assign beat_done = out_ready && pair_valid_reg;
    assign take      = pend && (!pair_valid_reg || (beat_done && phase_reg));

    always_comb
    begin
        pair_valid_next = pair_valid_reg;
        phase_next      = phase_reg;
        if (take)
        begin
            pair_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (beat_done)
        begin
            pair_valid_next = !phase_reg;
            phase_next      = !phase_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= pair_valid_next;
            phase_reg      <= phase_next;
        end
    end

    // pair payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            even_reg <= even;
            odd_reg  <= odd_sat;
        end
    end

    assign out_valid = pair_valid_reg;
    assign value     = phase_reg ? odd_reg : even_reg;
    assign last      = phase_reg;

`ifndef SYNTHESIS
    // a freshly loaded pair starts with the even beat
    a_load_even: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (pair_valid_reg && !phase_reg))
        else $error("pair load did not start on the even beat");

    // the even beat is always followed by the odd beat of the same pair
    a_odd_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_done && !phase_reg) |=> (pair_valid_reg && phase_reg))
        else $error("odd beat missing after even beat");

    // a waiting beat keeps its payload until it is accepted
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(last)))
        else $error("output beat changed while waiting");
`endif

endmodule

// File: design/fir_interpolator_x2_q15_unit.sv
// fir_interpolator_x2_q15_unit: top level of the x2 polyphase interpolator.
// Uses fi2_pkg, fi2_tap_cell and fi2_pair_out.
//
// Takes signed q15 samples and returns two q15 results per sample: first the
// even phase (the sample taken 15 beats earlier, last = 0), then the odd phase
// from a 30-cell transposed filter chain, rounded half away from zero and
// saturated (last = 1). The first 15 samples after reset give no results, nor
// do a sample with restart set and the 14 after it; flush the tail with 15
// zero samples. In steady state the sample rate is set by the single output
// port, which sends two beats per sample and can be held by out_ready; each
// pair passes the chain register, then the pair buffer, before it appears.
// With out_ready held low the block still takes one more sample before stalling.
module fir_interpolator_x2_q15_unit
    import fi2_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] value,
    output logic                       last
);

    chain_ctrl_t                ctrl;
    logic                       in_fire;
    logic                       take;
    logic                       due;
    logic [CNT_W-1:0]           cnt_eff;
    logic [CNT_W-1:0]           warm_cnt_reg;
    logic [CNT_W-1:0]           warm_cnt_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic signed [SAMPLE_W-1:0] hist_reg [LAG+1];
    logic signed [ACC_W-1:0]    acc_chain [NUM_CELLS+1];

    // input handshake: the chain result must be moved before it is replaced
    assign in_ready     = !pend_reg || take;
    assign in_fire      = in_valid && in_ready;
    assign ctrl.advance = in_fire;
    assign ctrl.clear   = restart;

    // warm-up count, restart clears it before the beat counts
    assign cnt_eff = restart ? '0 : warm_cnt_reg;
    assign due     = (cnt_eff == CNT_W'(LAG));

    always_comb
    begin
        warm_cnt_next = warm_cnt_reg;
        pend_next     = pend_reg;
        if (in_fire)
        begin
            warm_cnt_next = due ? cnt_eff : cnt_eff + CNT_W'(1);
            pend_next     = due;
        end
        else if (take)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            warm_cnt_reg <= warm_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    // sample delay line feeding the even phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAG; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i <= LAG; i++)
            begin
                hist_reg[i] <= restart ? '0 : hist_reg[i-1];
            end
        end
    end

    // odd-phase filter: chain of cells, sums travel towards cell 0
    assign acc_chain[NUM_CELLS] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fi2_tap_cell #(
            .COEF (ODD_COEF[g])
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .sample  (sample),
            .acc_in  (acc_chain[g+1]),
            .acc_out (acc_chain[g])
        );
    end

    // pair buffer and output port
    fi2_pair_out u_pair_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .pend      (pend_reg),
        .acc       (acc_chain[0]),
        .even      (hist_reg[LAG]),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .last      (last)
    );

`ifndef SYNTHESIS
    // a restart beat never produces a pair
    a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart) |=> !pend_reg)
        else $error("pair raised on a restart beat");

    // warm-up count saturates at the lag
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        warm_cnt_reg <= CNT_W'(LAG))
        else $error("warm-up count out of range");

    // a pending result is held until the pair buffer takes it
    a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !take) |=> pend_reg)
        else $error("pending result lost");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the x2 q15 polyphase interpolator.
// Depends on fi2_pkg and fir_interpolator_x2_q15_unit; predicts every output pair
// from its own copy of the 61-tap filter and checks each beat in order.
module tb_top
    import fi2_pkg::*;
();

    // filter geometry, as seen on the upsampled stream
    localparam int TAP_COUNT = 61;
    localparam int MID_TAP   = (TAP_COUNT - 1) / 2;
    localparam int PAIR_LAG  = (MID_TAP + 1) / 2;
    localparam int HIST_LEN  = 2 * PAIR_LAG + 1;
    localparam int RND_ITEMS = 1950;
    localparam int MAX_SHOWN = 10;
    localparam int DRAIN_CYC = 20;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    // full windowed-sinc rom at scale 2^15
    localparam int FIR_ROM [TAP_COUNT] = '{
        0, 59, 0, -79, 0, 118, 0, -180, 0, 268, 0, -387, 0, 545, 0, -751,
        0, 1020, 0, -1379, 0, 1878, 0, -2628, 0, 3915, 0, -6797, 0, 20808,
        32768,
        20808, 0, -6797, 0, 3915, 0, -2628, 0, 1878, 0, -1379, 0, 1020, 0,
        -751, 0, 545, 0, -387, 0, 268, 0, -180, 0, 118, 0, -79, 0, 59, 0
    };

    // content styles of a random segment
    typedef enum int {
        SEG_UNIFORM,
        SEG_EXTREME,
        SEG_CONST,
        SEG_SMALL,
        SEG_IMPULSE
    } seg_kind_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } in_beat_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } out_beat_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       restart   = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;

    in_beat_t  sample_q [$];
    out_beat_t interp_q [$];

    // predictor state
    logic signed [SAMPLE_W-1:0] hist [HIST_LEN];
    int                         warm_cnt = 0;

    int   fail_cnt  = 0;
    logic in_took   = 1'b0;
    logic out_took  = 1'b0;
    int   in_gap    = 0;
    int   out_stall = 0;
    logic in_burst  = 1'b0;
    logic out_burst = 1'b0;

    fir_interpolator_x2_q15_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .last      (last)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // round half away from zero by 2^15, then clamp to int16
    function automatic logic signed [SAMPLE_W-1:0] round_clamp(input longint acc);
        longint mag;
        longint rnd;
        mag = (acc < 0) ? -acc : acc;
        rnd = (mag + (longint'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
        if (acc < 0)
        begin
            if (rnd > 32768)
                return S_MIN;
            return SAMPLE_W'(-rnd);
        end
        if (rnd > 32767)
            return S_MAX;
        return SAMPLE_W'(rnd);
    endfunction

    // take one sample into the history and queue the pair it releases
    task automatic interp_step(input logic signed [SAMPLE_W-1:0] s, input logic rs);
        longint    acc;
        int        ph;
        int        k;
        int        d;
        out_beat_t res;
        if (rs)
        begin
            for (k = 0; k < HIST_LEN; k++)
                hist[k] = '0;
            warm_cnt = 0;
        end
        for (k = HIST_LEN - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = s;
        // warm-up: history fills, nothing comes out
        if (warm_cnt < PAIR_LAG)
        begin
            warm_cnt++;
            return;
        end
        for (ph = 0; ph < 2; ph++)
        begin
            acc = 0;
            for (k = 0; k < TAP_COUNT; k++)
            begin
                if (((ph + k - MID_TAP) & 1) == 0)
                begin
                    d = (2 * PAIR_LAG - ph - k + MID_TAP) / 2;
                    if (d >= 0 && d < HIST_LEN)
                        acc += longint'(FIR_ROM[k]) * longint'(hist[d]);
                end
            end
            res.value = round_clamp(acc);
            res.last  = (ph == 1);
            interp_q.push_back(res);
        end
    endtask

    task automatic add_beat(input logic signed [SAMPLE_W-1:0] s, input logic rs);
        in_beat_t it;
        it.sample  = s;
        it.restart = rs;
        sample_q.push_back(it);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input seg_kind_t kind,
                                                               input logic signed [SAMPLE_W-1:0] hold);
        case (kind)
            SEG_EXTREME: return $urandom_range(0, 1) ? S_MAX : S_MIN;
            SEG_CONST:   return hold;
            SEG_SMALL:   return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            SEG_IMPULSE: return ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : '0;
            default:     return SAMPLE_W'($urandom);
        endcase
    endfunction

    // stimulus, reset and end of run
    initial
    begin : stim
        int        i;
        int        seg_len;
        seg_kind_t kind;
        logic signed [SAMPLE_W-1:0] hold;

        for (i = 0; i < HIST_LEN; i++)
            hist[i] = '0;

        // directed: positive full scale saturates the odd phase once warm
        add_beat(S_MAX, 1'b1);
        for (i = 0; i < 15; i++)
            add_beat(S_MAX, 1'b0);
        // step down to negative full scale, then mixed extremes
        for (i = 0; i < 5; i++)
            add_beat(S_MIN, 1'b0);
        add_beat('0, 1'b0);
        add_beat(S_MAX, 1'b0);
        // restart mid-stream with a non-zero sample
        add_beat(-16'sd1, 1'b1);
        add_beat(S_MIN, 1'b0);

        // random segments: mostly restart, content, zero flush
        while (sample_q.size() < RND_ITEMS)
        begin
            kind    = seg_kind_t'($urandom_range(0, 4));
            hold    = $urandom_range(0, 1) ? S_MAX : S_MIN;
            seg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14)
                                                  : $urandom_range(16, 80);
            for (i = 0; i < seg_len; i++)
                add_beat(pick_sample(kind, hold),
                         (i == 0) ? ($urandom_range(0, 4) != 0)
                                  : ($urandom_range(0, 99) < 2));
            if ($urandom_range(0, 5) != 0)
                for (i = 0; i < PAIR_LAG; i++)
                    add_beat('0, 1'b0);
        end
        for (i = 0; i < PAIR_LAG; i++)
            add_beat('0, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sample_q.size() != 0 || in_valid)
            @(posedge clk);
        while (interp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (fail_cnt == 0 && interp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // input driver: one beat per queued item, random gap before each
    always @(negedge clk)
    begin : drive_in
        logic     vld_nxt;
        in_beat_t it;
        if (rst_n)
        begin
            vld_nxt = in_valid;
            if (in_valid && in_took)
                vld_nxt = 1'b0;
            if (!vld_nxt)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (sample_q.size() != 0)
                begin
                    it = sample_q.pop_front();
                    sample  <= it.sample;
                    restart <= it.restart;
                    vld_nxt = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        in_burst = ~in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 9);
                end
            end
            in_valid <= vld_nxt;
        end
    end

    // output ready: random stall after each accepted result beat
    always @(negedge clk)
    begin : drive_out
        if (rst_n)
        begin
            if (out_took)
            begin
                if ($urandom_range(0, 39) == 0)
                    out_burst = ~out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 9);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: check result beats, predict from accepted sample beats
    always @(posedge clk)
    begin : monitor
        out_beat_t exp_b;
        in_took  <= rst_n && in_valid && in_ready;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (interp_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("unexpected result beat: value %0d last %0b", value, last);
                end
                else
                begin
                    exp_b = interp_q.pop_front();
                    if (value !== exp_b.value || last !== exp_b.last)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_SHOWN)
                            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                                     exp_b.value, exp_b.last, value, last);
                    end
                end
            end
            if (in_valid && in_ready)
                interp_step(sample, restart);
        end
    end

endmodule
